// ===== rtl/bfsp_pkg.sv =====
// Shared types and constants of the Bellman-Ford shortest-path block.
package bfsp_pkg;

   localparam int NODE_ID_W = 5;
   localparam int COST_IN_W = 16;
   localparam int DIST_W = 31;
   localparam int CFG_W = 6;
   localparam int CMP_W = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [DIST_W-1:0] DIST_INF = 31'h3fffffff;
   localparam logic signed [31:0] SUM_MAX = 32'sh3fffffff;
   localparam logic signed [31:0] SUM_MIN = 32'shc0000000;
   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 6'd32;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2,
      OP_CHECK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_PASS,
      ST_PASS_END,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   typedef struct packed {
      logic              reached;
      logic [DIST_W-1:0] dist_val;
   } dist_entry_type;

endpackage

// ===== rtl/bfsp_edge_mem.sv =====
// Edge table memory: one write port, one registered read port.
module bfsp_edge_mem #(
   parameter int DEPTH = 256,
   parameter int AW = 8,
   parameter int DW = 26
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [0:DEPTH-1];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfsp_dist_mem.sv =====
// Node distance memory: one write port, two registered read ports, read-first.
module bfsp_dist_mem #(
   parameter int DEPTH = 32,
   parameter int AW = 5
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  bfsp_pkg::dist_entry_type wr_data,
   input  logic [AW-1:0]           rd_a_addr,
   output bfsp_pkg::dist_entry_type rd_a_data,
   input  logic [AW-1:0]           rd_b_addr,
   output bfsp_pkg::dist_entry_type rd_b_data
);

   bfsp_pkg::dist_entry_type mem [0:DEPTH-1];
   bfsp_pkg::dist_entry_type rd_a_ff;
   bfsp_pkg::dist_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== rtl/bellman_ford_shortest_path.sv =====
// Top level of the Bellman-Ford shortest-path block: control, relaxation pipeline, output.
//
//   Channel   Direction  Payload                                     Handshake
//   req_*     in         tuser: operation; tdata: edges and source   tvalid/tready
//   rsp_*     out        tdata: node result; tlast; tuser: status    tvalid/tready
//   csr_*     in         data: node_count                            valid/ready
//
// A clear is answered by no result; an add is answered by one result.
// A run first initialises the distance entry of each of its n nodes, then makes up to n
// passes over the loaded edges; the relaxation pipeline retires one edge per cycle.
// Results of a run leave one per node, each read from the distance memory, then loaded.
// Reset is synchronous; it empties the edge table and sets node_count to 32.
// A stalled result holds the output register; new requests wait until it is taken.
module bellman_ford_shortest_path #(
   parameter int MAX_NODES = 32,
   parameter int MAX_EDGES = 256,
   parameter int COST_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // edge_from[4:0], edge_to[9:5], edge_cost[25:10], source_node[30:26], zero[31]
   input  logic [bfsp_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // node_index[4:0], distance[35:5], reachable[36], negative_cycle[37], zero[39:38]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // status[0]
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int NCNT_W = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W = $clog2(MAX_EDGES + 1);
   localparam int ID_W = bfsp_pkg::NODE_ID_W;
   localparam int EDGE_DW = 2 * ID_W + COST_BITS;

   bfsp_pkg::state_type state_ff, state_in;

   logic [bfsp_pkg::CFG_W-1:0] node_count_ff, node_count_in;
   logic [ECNT_W-1:0]  edges_loaded_ff, edges_loaded_in;
   logic [ECNT_W-1:0]  edge_cnt_ff, edge_cnt_in;
   logic               check_ff, check_in;
   logic [ID_W-1:0]    source_ff, source_in;
   logic [NCNT_W-1:0]  n_ff, n_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [NCNT_W-1:0]  pass_ff, pass_in;
   logic               changed_ff, changed_in;
   logic               flag_ff, flag_in;
   logic               s1_vld_ff, s1_vld_in;
   logic               s2_vld_ff, s2_vld_in;
   logic               s2_ok_ff, s2_ok_in;
   logic [NODE_W-1:0]  s2_tail_ff, s2_tail_in;
   logic [NODE_W-1:0]  s2_head_ff, s2_head_in;
   logic [COST_BITS-1:0] s2_cost_ff, s2_cost_in;
   logic               wr_vld_ff, wr_vld_in;
   logic [NODE_W-1:0]  wr_addr_ff, wr_addr_in;
   bfsp_pkg::dist_entry_type wr_data_ff, wr_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [bfsp_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               edge_we;
   logic [EDGE_DW-1:0] edge_wdata;
   logic [EDGE_AW-1:0] edge_raddr;
   logic [EDGE_DW-1:0] edge_rdata;
   logic               dist_we;
   logic [NODE_W-1:0]  dist_waddr;
   bfsp_pkg::dist_entry_type dist_wdata;
   logic [NODE_W-1:0]  dist_raddr_a;
   logic [NODE_W-1:0]  dist_raddr_b;
   bfsp_pkg::dist_entry_type dist_rdata_a;
   bfsp_pkg::dist_entry_type dist_rdata_b;

   logic               req_accept;
   logic               rsp_free;
   logic               issue;
   logic [1:0]         req_op;
   logic [ID_W-1:0]    req_from;
   logic [ID_W-1:0]    req_to;
   logic [bfsp_pkg::COST_IN_W-1:0] req_cost;
   logic [ID_W-1:0]    req_source;
   logic [23:0]        cost_wide;
   logic [ID_W-1:0]    s1_tail;
   logic [ID_W-1:0]    s1_head;
   bfsp_pkg::dist_entry_type tail_entry;
   bfsp_pkg::dist_entry_type head_entry;
   logic signed [31:0] sum;
   logic signed [31:0] cand;
   logic signed [31:0] head_dist;
   logic               relax;
   logic               emit_last;
   logic [bfsp_pkg::DIST_W-1:0] emit_dist;

   assign req_op     = req_tuser;
   assign req_from   = req_tdata[4:0];
   assign req_to     = req_tdata[9:5];
   assign req_cost   = req_tdata[25:10];
   assign req_source = req_tdata[30:26];
   assign cost_wide  = {{(24 - bfsp_pkg::COST_IN_W){req_cost[bfsp_pkg::COST_IN_W-1]}}, req_cost};

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == bfsp_pkg::ST_IDLE) && rsp_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign issue      = (state_ff == bfsp_pkg::ST_PASS) && (edge_cnt_ff < edges_loaded_ff);

   assign s1_tail = edge_rdata[COST_BITS+2*ID_W-1:COST_BITS+ID_W];
   assign s1_head = edge_rdata[COST_BITS+ID_W-1:COST_BITS];

   assign tail_entry = (wr_vld_ff && wr_addr_ff == s2_tail_ff) ? wr_data_ff : dist_rdata_a;
   assign head_entry = (wr_vld_ff && wr_addr_ff == s2_head_ff) ? wr_data_ff : dist_rdata_b;
   assign sum = {tail_entry.dist_val[bfsp_pkg::DIST_W-1], tail_entry.dist_val}
              + {{(32 - COST_BITS){s2_cost_ff[COST_BITS-1]}}, s2_cost_ff};
   assign head_dist = {head_entry.dist_val[bfsp_pkg::DIST_W-1], head_entry.dist_val};
   assign relax = s2_vld_ff && s2_ok_ff && tail_entry.reached
                  && (!head_entry.reached || cand < head_dist);

   assign emit_last = ({1'b0, NCNT_W'(node_ff)} == ({1'b0, n_ff} - 1'b1));
   assign emit_dist = dist_rdata_a.reached ? dist_rdata_a.dist_val : bfsp_pkg::DIST_INF;

   always_comb begin
      priority if (sum > bfsp_pkg::SUM_MAX) begin
         cand = bfsp_pkg::SUM_MAX;
      end else if (sum < bfsp_pkg::SUM_MIN) begin
         cand = bfsp_pkg::SUM_MIN;
      end else begin
         cand = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      node_count_in   = node_count_ff;
      edges_loaded_in = edges_loaded_ff;
      edge_cnt_in     = edge_cnt_ff;
      check_in        = check_ff;
      source_in       = source_ff;
      n_in            = n_ff;
      node_in         = node_ff;
      pass_in         = pass_ff;
      changed_in      = changed_ff;
      flag_in         = flag_ff;
      s1_vld_in       = 1'b0;
      s2_vld_in       = s1_vld_ff;
      s2_ok_in        = (bfsp_pkg::CMP_W'(s1_tail) < bfsp_pkg::CMP_W'(n_ff))
                        && (bfsp_pkg::CMP_W'(s1_head) < bfsp_pkg::CMP_W'(n_ff));
      s2_tail_in      = NODE_W'(s1_tail);
      s2_head_in      = NODE_W'(s1_head);
      s2_cost_in      = edge_rdata[COST_BITS-1:0];
      wr_vld_in       = 1'b0;
      wr_addr_in      = s2_head_ff;
      wr_data_in      = '{reached: 1'b1, dist_val: cand[bfsp_pkg::DIST_W-1:0]};
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_status_in   = rsp_status_ff;

      edge_we      = 1'b0;
      edge_wdata   = {req_from, req_to, cost_wide[COST_BITS-1:0]};
      edge_raddr   = edge_cnt_ff[EDGE_AW-1:0];
      dist_we      = 1'b0;
      dist_waddr   = node_ff;
      dist_wdata   = '{reached: 1'b0, dist_val: bfsp_pkg::DIST_INF};
      dist_raddr_a = node_ff;
      dist_raddr_b = node_ff;

      if (csr_valid && csr_ready) begin
         node_count_in = csr_data;
      end

      unique case (state_ff)
         bfsp_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (bfsp_pkg::op_type'(req_op))
                  bfsp_pkg::OP_CLEAR: begin
                     edges_loaded_in = '0;
                  end
                  bfsp_pkg::OP_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = (edges_loaded_ff == ECNT_W'(MAX_EDGES));
                     if (edges_loaded_ff != ECNT_W'(MAX_EDGES)) begin
                        edge_we         = 1'b1;
                        edges_loaded_in = edges_loaded_ff + 1'b1;
                     end
                  end
                  bfsp_pkg::OP_RUN, bfsp_pkg::OP_CHECK: begin
                     check_in  = (bfsp_pkg::op_type'(req_op) == bfsp_pkg::OP_CHECK);
                     source_in = req_source;
                     node_in   = '0;
                     if (node_count_ff == '0) begin
                        n_in = NCNT_W'(1);
                     end else if ({1'b0, node_count_ff} > bfsp_pkg::CMP_W'(MAX_NODES)) begin
                        n_in = NCNT_W'(MAX_NODES);
                     end else begin
                        n_in = NCNT_W'(node_count_ff);
                     end
                     state_in = bfsp_pkg::ST_INIT;
                  end
                  default: begin
                     state_in = bfsp_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         bfsp_pkg::ST_INIT: begin
            dist_we = 1'b1;
            if (check_ff || bfsp_pkg::CMP_W'(source_ff) == bfsp_pkg::CMP_W'(node_ff)) begin
               dist_wdata = '{reached: 1'b1, dist_val: '0};
            end
            if (emit_last) begin
               node_in     = '0;
               pass_in     = '0;
               edge_cnt_in = '0;
               changed_in  = 1'b0;
               flag_in     = 1'b0;
               state_in    = bfsp_pkg::ST_PASS;
            end else begin
               node_in = node_ff + 1'b1;
            end
         end
         bfsp_pkg::ST_PASS: begin
            dist_raddr_a = NODE_W'(s1_tail);
            dist_raddr_b = NODE_W'(s1_head);
            if (issue) begin
               s1_vld_in   = 1'b1;
               edge_cnt_in = edge_cnt_ff + 1'b1;
            end
            if (relax) begin
               dist_we    = 1'b1;
               dist_waddr = s2_head_ff;
               dist_wdata = wr_data_in;
               wr_vld_in  = 1'b1;
               changed_in = 1'b1;
            end
            if (!issue && !s1_vld_ff && !s2_vld_ff) begin
               state_in = bfsp_pkg::ST_PASS_END;
            end
         end
         bfsp_pkg::ST_PASS_END: begin
            priority if (!changed_ff) begin
               state_in = bfsp_pkg::ST_EMIT_RD;
            end else if ({1'b0, pass_ff} == ({1'b0, n_ff} - 1'b1)) begin
               flag_in  = 1'b1;
               state_in = bfsp_pkg::ST_EMIT_RD;
            end else begin
               pass_in     = pass_ff + 1'b1;
               edge_cnt_in = '0;
               changed_in  = 1'b0;
               state_in    = bfsp_pkg::ST_PASS;
            end
         end
         bfsp_pkg::ST_EMIT_RD: begin
            state_in = bfsp_pkg::ST_EMIT_LD;
         end
         bfsp_pkg::ST_EMIT_LD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {2'b00, flag_ff, dist_rdata_a.reached, emit_dist, ID_W'(node_ff)};
               rsp_last_in   = emit_last;
               rsp_status_in = 1'b0;
               if (emit_last) begin
                  state_in = bfsp_pkg::ST_IDLE;
               end else begin
                  node_in  = node_ff + 1'b1;
                  state_in = bfsp_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = bfsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= bfsp_pkg::NODE_COUNT_RESET;
         edges_loaded_ff <= '0;
         edge_cnt_ff     <= '0;
         pass_ff         <= '0;
         changed_ff      <= 1'b0;
         flag_ff         <= 1'b0;
         s1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
         wr_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         node_count_ff   <= node_count_in;
         edges_loaded_ff <= edges_loaded_in;
         edge_cnt_ff     <= edge_cnt_in;
         pass_ff         <= pass_in;
         changed_ff      <= changed_in;
         flag_ff         <= flag_in;
         s1_vld_ff       <= s1_vld_in;
         s2_vld_ff       <= s2_vld_in;
         wr_vld_ff       <= wr_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      check_ff      <= check_in;
      source_ff     <= source_in;
      n_ff          <= n_in;
      node_ff       <= node_in;
      s2_ok_ff      <= s2_ok_in;
      s2_tail_ff    <= s2_tail_in;
      s2_head_ff    <= s2_head_in;
      s2_cost_ff    <= s2_cost_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   bfsp_edge_mem #(
      .DEPTH (MAX_EDGES),
      .AW    (EDGE_AW),
      .DW    (EDGE_DW)
   ) u_edge_mem (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edges_loaded_ff[EDGE_AW-1:0]),
      .wr_data (edge_wdata),
      .rd_addr (edge_raddr),
      .rd_data (edge_rdata)
   );

   bfsp_dist_mem #(
      .DEPTH (MAX_NODES),
      .AW    (NODE_W)
   ) u_dist_mem (
      .clock     (clock),
      .wr_en     (dist_we),
      .wr_addr   (dist_waddr),
      .wr_data   (dist_wdata),
      .rd_a_addr (dist_raddr_a),
      .rd_a_data (dist_rdata_a),
      .rd_b_addr (dist_raddr_b),
      .rd_b_data (dist_rdata_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_pass_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfsp_pkg::ST_PASS) |-> (pass_ff < n_ff))
      else $error("pass counter reached the node count during relaxation");

   a_edge_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfsp_pkg::ST_PASS) |-> (edge_cnt_ff <= edges_loaded_ff))
      else $error("edge cursor ran past the loaded edges");

   a_relax_needs_stage: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfsp_pkg::ST_PASS && dist_we) |-> s2_vld_ff)
      else $error("distance written without an edge in the compare stage");

   a_quiet_pass_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfsp_pkg::ST_PASS_END && !changed_ff) |=>
      (state_ff == bfsp_pkg::ST_EMIT_RD && !flag_ff))
      else $error("unchanged pass did not end the run cleanly");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      edges_loaded_ff <= ECNT_W'(MAX_EDGES))
      else $error("edge count exceeds table depth");

endmodule

// ===== verif/bellman_ford_shortest_path_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Bellman-Ford shortest-path block with a built-in predictor.
module bellman_ford_shortest_path_test;

   localparam int NODE_SLOTS = 32;
   localparam int EDGE_SLOTS = 256;
   localparam int RANDOM_ITEMS = 75;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES = 100;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [4:0]                  node;
      logic [bfsp_pkg::DIST_W-1:0] distance;
      logic                        reachable;
      logic                        neg_cycle;
      logic                        last;
      logic                        status;
   } node_report_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type                kind;
      bfsp_pkg::op_type            op;
      logic [4:0]                  from;
      logic [4:0]                  to;
      logic signed [15:0]          cost;
      logic [4:0]                  src;
      logic [bfsp_pkg::CFG_W-1:0]  count;
      bit                          typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bfsp_pkg::CFG_W-1:0] csr_data = '0;

   bellman_ford_shortest_path DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [4:0] tail_table [EDGE_SLOTS];
   logic [4:0] head_table [EDGE_SLOTS];
   logic signed [15:0] weight_table [EDGE_SLOTS];
   int edges_held = 0;
   logic [bfsp_pkg::CFG_W-1:0] node_limit = bfsp_pkg::NODE_COUNT_RESET;

   node_report_type awaited_reports[$];
   node_report_type fresh_reports[$];
   stim_row_type directed_rows[$];
   int fault_count = 0;
   int sent_count = 0;
   int cycle_count = 0;
   int ready_hold = 0;
   int ready_roll;
   bit burst_mode = 1'b0;

   function automatic int nodes_active(input logic [bfsp_pkg::CFG_W-1:0] count);
      if (count == 0) return 1;
      if (count > NODE_SLOTS) return NODE_SLOTS;
      return int'(count);
   endfunction

   task automatic compute_reports(input bfsp_pkg::op_type op, input logic [4:0] from,
         input logic [4:0] to, input logic signed [15:0] cost, input logic [4:0] src);
      int span;
      int f;
      int t;
      int path_len [NODE_SLOTS];
      bit hit [NODE_SLOTS];
      bit moved;
      bit cyc;
      longint sum;
      node_report_type r;
      fresh_reports.delete();
      r = '0;
      case (op)
         bfsp_pkg::OP_CLEAR: begin
            edges_held = 0;
         end
         bfsp_pkg::OP_ADD: begin
            r.last = 1'b1;
            if (edges_held < EDGE_SLOTS) begin
               tail_table[edges_held] = from;
               head_table[edges_held] = to;
               weight_table[edges_held] = cost;
               edges_held++;
            end else begin
               r.status = 1'b1;
            end
            fresh_reports = {fresh_reports, r};
         end
         default: begin
            span = nodes_active(node_limit);
            for (int i = 0; i < NODE_SLOTS; i++) begin
               path_len[i] = (op == bfsp_pkg::OP_CHECK) ? 0 : int'(bfsp_pkg::DIST_INF);
               hit[i] = (op == bfsp_pkg::OP_CHECK);
            end
            if (op == bfsp_pkg::OP_RUN && int'(src) < span) begin
               path_len[src] = 0;
               hit[src] = 1'b1;
            end
            cyc = 1'b0;
            for (int pass = 0; pass < span; pass++) begin
               moved = 1'b0;
               for (int e = 0; e < edges_held; e++) begin
                  f = tail_table[e];
                  t = head_table[e];
                  if (f >= span || t >= span || !hit[f]) continue;
                  sum = longint'(path_len[f]) + longint'(weight_table[e]);
                  if (sum > longint'(bfsp_pkg::SUM_MAX)) sum = longint'(bfsp_pkg::SUM_MAX);
                  if (sum < longint'(bfsp_pkg::SUM_MIN)) sum = longint'(bfsp_pkg::SUM_MIN);
                  if (!hit[t] || sum < longint'(path_len[t])) begin
                     path_len[t] = int'(sum);
                     hit[t] = 1'b1;
                     moved = 1'b1;
                  end
               end
               if (!moved) break;
               if (pass == span - 1) cyc = 1'b1;
            end
            for (int i = 0; i < span; i++) begin
               r.node = i[4:0];
               r.distance = hit[i] ? path_len[i][bfsp_pkg::DIST_W-1:0] : bfsp_pkg::DIST_INF;
               r.reachable = hit[i];
               r.neg_cycle = cyc;
               r.last = (i == span - 1);
               r.status = 1'b0;
               fresh_reports = {fresh_reports, r};
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input bfsp_pkg::op_type op, input logic [4:0] from,
         input logic [4:0] to, input logic signed [15:0] cost, input logic [4:0] src,
         input bit typed);
      int gap;
      node_report_type ack;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, src, cost, to, from};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      compute_reports(op, from, to, cost, src);
      if (typed) begin
         ack = '0;
         ack.last = 1'b1;
         awaited_reports = {awaited_reports, ack};
      end else begin
         awaited_reports = {awaited_reports, fresh_reports};
      end
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [bfsp_pkg::CFG_W-1:0] count);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_data <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      node_limit = count;
   endtask

   function automatic logic [4:0] random_node(input int span);
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(0, span - 1));
   endfunction

   function automatic logic signed [15:0] random_cost();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'($urandom);
      if (roll < 3) return 16'(int'($urandom_range(0, 20)) - 12);
      return 16'($urandom_range(0, 60));
   endfunction

   function automatic stim_row_type req_row(input bfsp_pkg::op_type op, input int from,
         input int to, input int cost, input int src, input bit typed);
      stim_row_type r;
      r.kind = ROW_REQUEST;
      r.op = op;
      r.from = from[4:0];
      r.to = to[4:0];
      r.cost = cost[15:0];
      r.src = src[4:0];
      r.count = '0;
      r.typed = typed;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input int count);
      stim_row_type r;
      r = req_row(bfsp_pkg::OP_CLEAR, 0, 0, 0, 0, 1'b0);
      r.kind = ROW_CSR;
      r.count = count[bfsp_pkg::CFG_W-1:0];
      return r;
   endfunction

   function automatic void add_row(input stim_row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bellman_ford_shortest_path_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 60) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 12);
         end else if (ready_roll < 85) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
         end else if (ready_roll < 93) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(40, 200);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      node_report_type got;
      node_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.node = rsp_tdata[4:0];
         got.distance = rsp_tdata[35:5];
         got.reachable = rsp_tdata[36];
         got.neg_cycle = rsp_tdata[37];
         got.last = rsp_tlast;
         got.status = rsp_tuser;
         if (awaited_reports.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("Unexpected result transaction: node %0d distance %0d", got.node,
                  $signed(got.distance));
         end else begin
            want = awaited_reports.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display({"Result mismatch: node %0d/%0d distance %0d/%0d reachable %0b/%0b",
                     " negative_cycle %0b/%0b last %0b/%0b status %0b/%0b (expected/actual)"},
                     want.node, got.node, $signed(want.distance), $signed(got.distance),
                     want.reachable, got.reachable, want.neg_cycle, got.neg_cycle,
                     want.last, got.last, want.status, got.status);
            end
         end
      end
   end

   initial begin
      int span;
      int goal;
      int roll;
      logic [bfsp_pkg::CFG_W-1:0] count;

      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 0, 1'b0));
      add_row(req_row(bfsp_pkg::OP_ADD, 0, 1, 5, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_ADD, 1, 2, -3, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_ADD, 31, 0, 32767, 31, 1'b1));
      add_row(req_row(bfsp_pkg::OP_ADD, 0, 31, -32768, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_ADD, 2, 3, 0, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 0, 1'b0));
      add_row(req_row(bfsp_pkg::OP_RUN, 31, 31, -1, 31, 1'b0));
      add_row(req_row(bfsp_pkg::OP_CHECK, 0, 0, 0, 0, 1'b0));
      add_row(req_row(bfsp_pkg::OP_CLEAR, 31, 31, -1, 31, 1'b0));
      add_row(req_row(bfsp_pkg::OP_ADD, 0, 1, -1, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_ADD, 1, 0, -1, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 0, 1'b0));
      add_row(csr_row(4));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 1, 1'b0));
      add_row(req_row(bfsp_pkg::OP_ADD, 2, 9, 7, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_ADD, 9, 2, 7, 0, 1'b1));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 10, 1'b0));
      add_row(req_row(bfsp_pkg::OP_CHECK, 0, 0, 0, 0, 1'b0));
      add_row(csr_row(0));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 0, 1'b0));
      add_row(req_row(bfsp_pkg::OP_CHECK, 0, 0, 0, 0, 1'b0));
      add_row(csr_row(63));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 31, 1'b0));
      add_row(req_row(bfsp_pkg::OP_CLEAR, 0, 0, 0, 0, 1'b0));
      add_row(req_row(bfsp_pkg::OP_RUN, 0, 0, 0, 0, 1'b0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_node_count(directed_rows[i].count);
         else
            send_request(directed_rows[i].op, directed_rows[i].from, directed_rows[i].to,
               directed_rows[i].cost, directed_rows[i].src, directed_rows[i].typed);
      end

      goal = sent_count + RANDOM_ITEMS;
      while (sent_count < goal) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0: count = 6'd1;
            1: count = 6'd0;
            2: count = 6'd32;
            3: count = 6'($urandom_range(33, 63));
            4: count = 6'($urandom);
            default: count = 6'($urandom_range(2, 8));
         endcase
         write_node_count(count);
         span = nodes_active(count);
         burst_mode = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) != 0) begin
               if ($urandom_range(0, 9) < 7)
                  send_request(bfsp_pkg::OP_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom),
                     5'($urandom), 1'b0);
               repeat ($urandom_range(1, 12))
                  send_request(bfsp_pkg::OP_ADD, random_node(span), random_node(span),
                     random_cost(), 5'($urandom), 1'b0);
               if ($urandom_range(0, 2) != 0)
                  send_request(bfsp_pkg::OP_RUN, 5'($urandom), 5'($urandom), 16'($urandom),
                     random_node(span), 1'b0);
               else
                  send_request(bfsp_pkg::OP_CHECK, 5'($urandom), 5'($urandom), 16'($urandom),
                     5'($urandom), 1'b0);
            end else begin
               repeat ($urandom_range(1, 4))
                  send_request(bfsp_pkg::op_type'($urandom_range(0, 3)), 5'($urandom),
                     5'($urandom), 16'($urandom), 5'($urandom), 1'b0);
            end
            if ($urandom_range(0, 5) == 0) drain_and_settle();
         end
      end
      burst_mode = 1'b0;

      drain_and_settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && awaited_reports.size() == 0)
         $display("bellman_ford_shortest_path_test: PASS");
      else
         $display("bellman_ford_shortest_path_test: FAIL");
      $finish;
   end

endmodule
